// ----- rtl/core/spp2_pkg.sv -----
// ----------------------------------------------------------------------------
// spp2_pkg
// Shared types and constants for the base-2 strong probable prime tester.
// ----------------------------------------------------------------------------
package spp2_pkg;
	localparam int WORDS = 4;
	localparam int LIMB_BITS = 32;
	localparam int NBITS = WORDS * LIMB_BITS;
	localparam int BIT_W = $clog2(NBITS);
	localparam int LD_W = $clog2(WORDS + 1);
	localparam int TW_W = 9;

	localparam logic [1:0] VERDICT_COMPOSITE = 2'd0;
	localparam logic [1:0] VERDICT_PRIME = 2'd1;
	localparam logic [1:0] VERDICT_TOO_LARGE = 2'd2;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_CHECK,
		ST_STRIP,
		ST_EXP_SQ,
		ST_EXP_DBL,
		ST_EXP_NEXT,
		ST_CMP,
		ST_FIN_SQ,
		ST_FIN_CMP,
		ST_DONE
	} state_t;

	// One modular operation request to the bit-serial unit
	typedef struct packed {
		logic start;
		logic dbl_only;
	} mop_req_t;
endpackage

// ----- rtl/core/spp2_modsq.sv -----
// ----------------------------------------------------------------------------
// spp2_modsq
// Bit-serial modular squaring or doubling: each multiplier bit is a doubling
// step then an add step, scanning from the top bit, shift-and-add with conditional subtract.
// ----------------------------------------------------------------------------
module spp2_modsq (
	input  logic                           clk,
	input  logic                           arst_n,
	input  spp2_pkg::mop_req_t             req,
	input  logic [spp2_pkg::NBITS-1:0]     a,
	input  logic [spp2_pkg::NBITS-1:0]     n,
	output logic                           done,
	output logic [spp2_pkg::NBITS-1:0]     r
);
	localparam int NB = spp2_pkg::NBITS;

	logic [NB-1:0] src_q, acc_q;
	logic [spp2_pkg::BIT_W-1:0] idx_q;
	logic busy_q, dbl_q, phase_q;
	logic [NB:0] dbl_w, dbl_s, add_w, add_s;
	logic [NB-1:0] dbl_r, add_r;

	// doubling and adding stages
	always_comb begin
		dbl_w = {acc_q, 1'b0};
		dbl_s = dbl_w - {1'b0, n};
		dbl_r = dbl_s[NB] ? dbl_w[NB-1:0] : dbl_s[NB-1:0];
		add_w = {1'b0, acc_q} + {1'b0, src_q};
		add_s = add_w - {1'b0, n};
		add_r = add_s[NB] ? add_w[NB-1:0] : add_s[NB-1:0];
	end

	// advance the scan: double in phase 0, add in phase 1 if bit set; a doubling-only request ends after its doubling
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			phase_q <= 1'b0;
			dbl_q <= 1'b0;
			idx_q <= '0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				dbl_q <= req.dbl_only;
				phase_q <= 1'b0;
				idx_q <= spp2_pkg::BIT_W'(NB - 1);
			end else if (busy_q) begin
				if (dbl_q) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end else if (!phase_q) begin
					phase_q <= 1'b1;
				end else begin
					phase_q <= 1'b0;
					if (idx_q == '0) begin
						busy_q <= 1'b0;
						done <= 1'b1;
					end else begin
						idx_q <= idx_q - 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			src_q <= a;
			acc_q <= req.dbl_only ? a : '0;
		end else if (busy_q) begin
			if (dbl_q || !phase_q) acc_q <= dbl_r;
			else if (src_q[idx_q]) acc_q <= add_r;
		end
	end

	assign r = acc_q;
endmodule

// ----- rtl/core/strong_probable_prime_base2.sv -----
// ----------------------------------------------------------------------------
// strong_probable_prime_base2
// Base-2 Miller-Rabin test of a multi-limb odd candidate.
// ----------------------------------------------------------------------------
// Limbs enter one per beat while busy is low, least significant first; the
// beat with last high starts the test and raises busy. One verdict strobe
// (done) follows per test and cannot be stalled. A test takes roughly
// (WORDS*32 + e) squarings on the shared bit-serial modular unit, plus a
// doubling per set exponent bit, after the factors of two are stripped from
// n-1. Rejected inputs finish without using the modular unit.
module strong_probable_prime_base2 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] limb,
	input  logic        last,
	output logic        done,
	output logic [1:0]  verdict
);
	localparam int NB = spp2_pkg::NBITS;

	spp2_pkg::state_t state_q, state_d;
	logic [NB-1:0] mod_q, d_q, pa_q;
	logic [spp2_pkg::LD_W-1:0] ld_q;
	logic tl_q;
	logic [spp2_pkg::TW_W-1:0] tw_q, k_q;
	logic [spp2_pkg::BIT_W-1:0] bi_q;
	logic [1:0] verdict_q;
	logic done_q;
	spp2_pkg::mop_req_t req;
	logic mop_done;
	logic [NB-1:0] mop_r;
	logic [NB-1:0] mop_a;
	logic accept;
	logic [NB-1:0] nm1;

	assign accept = start && !busy;
	assign busy = state_q != spp2_pkg::ST_LOAD;
	assign nm1 = mod_q - NB'(1);

	// forward a fresh result so a doubling right after a square sees it
	assign mop_a = mop_done ? mop_r : pa_q;

	spp2_modsq u_modsq (
		.clk(clk), .arst_n(arst_n), .req(req), .a(mop_a), .n(mod_q),
		.done(mop_done), .r(mop_r)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= spp2_pkg::ST_LOAD;
		else state_q <= state_d;
	end

	// next state and unit requests
	always_comb begin
		state_d = state_q;
		req = '0;
		unique case (state_q)
			spp2_pkg::ST_LOAD:
				if (accept && last) state_d = spp2_pkg::ST_CHECK;
			spp2_pkg::ST_CHECK: begin
				if (tl_q || !mod_q[0] || nm1 == '0) state_d = spp2_pkg::ST_DONE;
				else state_d = spp2_pkg::ST_STRIP;
			end
			spp2_pkg::ST_STRIP:
				if (d_q[0]) begin
					state_d = spp2_pkg::ST_EXP_SQ;
					req.start = 1'b1;
				end
			spp2_pkg::ST_EXP_SQ:
				if (mop_done) begin
					if (d_q[bi_q]) begin
						state_d = spp2_pkg::ST_EXP_DBL;
						req.start = 1'b1;
						req.dbl_only = 1'b1;
					end else state_d = spp2_pkg::ST_EXP_NEXT;
				end
			spp2_pkg::ST_EXP_DBL:
				if (mop_done) state_d = spp2_pkg::ST_EXP_NEXT;
			spp2_pkg::ST_EXP_NEXT:
				if (bi_q == '0) state_d = spp2_pkg::ST_CMP;
				else begin
					state_d = spp2_pkg::ST_EXP_SQ;
					req.start = 1'b1;
				end
			spp2_pkg::ST_CMP:
				if (pa_q == NB'(1) || pa_q == nm1 || k_q >= tw_q) state_d = spp2_pkg::ST_DONE;
				else begin
					state_d = spp2_pkg::ST_FIN_SQ;
					req.start = 1'b1;
				end
			spp2_pkg::ST_FIN_SQ:
				if (mop_done) state_d = spp2_pkg::ST_FIN_CMP;
			spp2_pkg::ST_FIN_CMP:
				if (pa_q == nm1 || k_q >= tw_q) state_d = spp2_pkg::ST_DONE;
				else begin
					state_d = spp2_pkg::ST_FIN_SQ;
					req.start = 1'b1;
				end
			spp2_pkg::ST_DONE: state_d = spp2_pkg::ST_LOAD;
			default: state_d = spp2_pkg::ST_LOAD;
		endcase
	end

	// control counters, verdict and strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_q <= '0;
			tl_q <= 1'b0;
			tw_q <= '0;
			k_q <= '0;
			bi_q <= '0;
			done_q <= 1'b0;
			verdict_q <= spp2_pkg::VERDICT_COMPOSITE;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				spp2_pkg::ST_LOAD:
					if (accept) begin
						if (ld_q < spp2_pkg::LD_W'(spp2_pkg::WORDS)) ld_q <= ld_q + 1'b1;
						else if (limb != '0) tl_q <= 1'b1;
					end
				spp2_pkg::ST_CHECK: begin
					tw_q <= '0;
					bi_q <= spp2_pkg::BIT_W'(NB - 1);
					k_q <= spp2_pkg::TW_W'(1);
					// start from composite, or too large if an extra limb was set; only a witness check can pass
					if (tl_q) verdict_q <= spp2_pkg::VERDICT_TOO_LARGE;
					else verdict_q <= spp2_pkg::VERDICT_COMPOSITE;
				end
				spp2_pkg::ST_STRIP:
					if (!d_q[0]) tw_q <= tw_q + 1'b1;
				spp2_pkg::ST_EXP_NEXT:
					if (bi_q != '0) bi_q <= bi_q - 1'b1;
				spp2_pkg::ST_CMP:
					if (pa_q == NB'(1) || pa_q == nm1) verdict_q <= spp2_pkg::VERDICT_PRIME;
				spp2_pkg::ST_FIN_SQ:
					if (mop_done) k_q <= k_q + 1'b1;
				spp2_pkg::ST_FIN_CMP:
					if (pa_q == nm1) verdict_q <= spp2_pkg::VERDICT_PRIME;
				spp2_pkg::ST_DONE: begin
					ld_q <= '0;
					tl_q <= 1'b0;
					done_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// payload: modulus load, exponent strip, power register
	always_ff @(posedge clk) begin
		if (state_q == spp2_pkg::ST_LOAD && accept) begin
			if (ld_q == '0 && !tl_q) begin
				mod_q <= {{(NB-32){1'b0}}, limb};
			end else if (ld_q < spp2_pkg::LD_W'(spp2_pkg::WORDS)) begin
				mod_q[ld_q[spp2_pkg::LD_W-1:0]*32 +: 32] <= limb;
			end
		end
		if (state_q == spp2_pkg::ST_CHECK) begin
			d_q <= nm1;
			pa_q <= NB'(1);
		end
		if (state_q == spp2_pkg::ST_STRIP && !d_q[0]) d_q <= d_q >> 1;
		if (mop_done) pa_q <= mop_r;
	end

	assign done = done_q;
	assign verdict = verdict_q;
endmodule

// ----- rtl/core/spp2_checker.sv -----
// ----------------------------------------------------------------------------
// spp2_checker
// Port-level checks of the prime tester, bound to the top level.
// ----------------------------------------------------------------------------
module spp2_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       last,
	input logic       done,
	input logic [1:0] verdict
);
	// a verdict is never the unused code
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> verdict <= spp2_pkg::VERDICT_TOO_LARGE) else $error("bad verdict code");
	// accepting a last beat raises busy
	a_go: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && last |=> busy) else $error("busy not raised");
	// a strobe is one cycle wide
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("strobe too long");
	// busy drops in the same cycle as the strobe
	a_rel: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done) else $error("busy fell without verdict");
endmodule

bind strong_probable_prime_base2 spp2_checker u_spp2_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .last(last),
	.done(done), .verdict(verdict)
);
